// ----- rtl/ucg_pkg.sv -----
// Shared types and constants for the ultrasonic collision guard.
// Holds event modes, drive command codes, H-bridge patterns, alert codes, register map.
// No dependencies.
package ucg_pkg;

  localparam int STAMP_BITS_DEF = 16;

  localparam int EDGE_W  = 16;
  localparam int CMD_W   = 8;
  localparam int RANGE_W = 8;
  localparam int SCALE_W = 16;
  localparam int LINES_W = 4;
  localparam int ALERT_W = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  typedef logic [1:0]         mode_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [LINES_W-1:0] lines_t;
  typedef logic [ALERT_W-1:0] alert_t;
  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [1:0]         reg_idx_t;

  localparam mode_t MODE_ECHO = 2'd0;
  localparam mode_t MODE_CMD  = 2'd1;
  localparam mode_t MODE_TICK = 2'd2;

  localparam cmd_t CMD_FORWARD  = 8'h46;
  localparam cmd_t CMD_BACKWARD = 8'h42;
  localparam cmd_t CMD_LEFT     = 8'h4C;
  localparam cmd_t CMD_RIGHT    = 8'h52;

  localparam lines_t LINES_STOP     = 4'b0000;
  localparam lines_t LINES_FORWARD  = 4'b1010;
  localparam lines_t LINES_BACKWARD = 4'b0101;
  localparam lines_t LINES_LEFT     = 4'b0110;
  localparam lines_t LINES_RIGHT    = 4'b1001;

  localparam alert_t ALERT_CLEAR     = 3'd0;
  localparam alert_t ALERT_WARN_FWD  = 3'd1;
  localparam alert_t ALERT_WARN_BACK = 3'd2;
  localparam alert_t ALERT_STOP_FWD  = 3'd3;
  localparam alert_t ALERT_STOP_BACK = 3'd4;

  localparam reg_idx_t REG_STOP  = 2'd0;
  localparam reg_idx_t REG_WARN  = 2'd1;
  localparam reg_idx_t REG_SCALE = 2'd2;

  localparam range_t             STOP_RST  = 8'd15;
  localparam range_t             WARN_RST  = 8'd30;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1114;
  localparam range_t             RANGE_MAX = 8'd255;

endpackage

// ----- rtl/ultrasonic_collision_guard_motor.sv -----
// Collision guard top level: echo pulse capture, drive command, threshold evaluation.
// An accepted request waits in the input register; its result is then registered.
// Throughput: one request per cycle while out_ready does not stall; a single compute
// stage with one width-by-scale multiply sits between input and result registers.
// Reset (rst_n, synchronous): thresholds 15/30 cm, scale 1114, all state zero.
// Depends on ucg_pkg.
module ultrasonic_collision_guard_motor #(
  parameter int STAMP_BITS = ucg_pkg::STAMP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ucg_pkg::mode_t              in_mode,
  input  logic                        in_echo_sensor,
  input  logic [ucg_pkg::EDGE_W-1:0]  in_edge_time,
  input  ucg_pkg::cmd_t               in_command_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ucg_pkg::lines_t             out_motor_lines,
  output ucg_pkg::alert_t             out_alert,
  output ucg_pkg::range_t             out_front_range,
  output ucg_pkg::range_t             out_back_range,
  output logic                        out_range_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ucg_pkg::ADDR_W-1:0]  paddr,
  input  logic [ucg_pkg::DATA_W-1:0]  pwdata,
  output logic [ucg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ucg_pkg::*;

  localparam int PROD_W = STAMP_BITS + SCALE_W;

  // configuration
  range_t             stop_dist_r, warn_dist_r;
  logic [SCALE_W-1:0] scale_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  // input register
  logic                  s1_valid_r;
  mode_t                 s1_mode_r;
  logic                  s1_sensor_r;
  logic [EDGE_W-1:0]     s1_edge_r;
  cmd_t                  s1_cmd_r;

  // state
  logic                  await_fall_r [2];
  logic [STAMP_BITS-1:0] rise_stamp_r [2];
  range_t                range_r      [2];
  cmd_t                  dir_r;
  logic                  fwd_blk_r, back_blk_r;
  lines_t                lines_r;
  alert_t                alert_r;

  // result register
  logic   out_valid_r;
  lines_t out_lines_r;
  alert_t out_alert_r;
  range_t out_front_r, out_back_r;
  logic   out_done_r;

  logic                  adv;
  logic [STAMP_BITS-1:0] stamp_ext, pulse_w;
  logic [PROD_W-1:0]     prod;
  logic [STAMP_BITS-1:0] cm_full;
  range_t                cm_sat;

  logic                  await_fall_nxt [2];
  logic [STAMP_BITS-1:0] rise_stamp_nxt [2];
  range_t                range_nxt      [2];
  cmd_t                  dir_nxt;
  logic                  fwd_blk_nxt, back_blk_nxt;
  lines_t                lines_nxt;
  alert_t                alert_nxt;
  logic                  done_nxt;
  logic                  is_fwd, is_back;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_STOP:  prdata = DATA_W'(stop_dist_r);
      REG_WARN:  prdata = DATA_W'(warn_dist_r);
      REG_SCALE: prdata = DATA_W'(scale_r);
      default:   prdata = '0;
    endcase
  end

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // pulse width with wrap, then scale to cm and saturate
  assign stamp_ext = STAMP_BITS'(s1_edge_r);
  assign pulse_w   = stamp_ext - rise_stamp_r[s1_sensor_r];
  assign prod      = PROD_W'(pulse_w) * PROD_W'(scale_r);
  assign cm_full   = prod[PROD_W-1:SCALE_W];
  assign cm_sat    = (cm_full > STAMP_BITS'(RANGE_MAX)) ? RANGE_MAX : cm_full[RANGE_W-1:0];

  assign is_fwd  = (dir_r == CMD_FORWARD);
  assign is_back = (dir_r == CMD_BACKWARD);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      await_fall_nxt[i] = await_fall_r[i];
      rise_stamp_nxt[i] = rise_stamp_r[i];
      range_nxt[i]      = range_r[i];
    end
    dir_nxt      = dir_r;
    fwd_blk_nxt  = fwd_blk_r;
    back_blk_nxt = back_blk_r;
    lines_nxt    = lines_r;
    alert_nxt    = alert_r;
    done_nxt     = 1'b0;
    case (s1_mode_r)
      MODE_ECHO: begin
        if (!await_fall_r[s1_sensor_r]) begin
          rise_stamp_nxt[s1_sensor_r] = stamp_ext;
          await_fall_nxt[s1_sensor_r] = 1'b1;
        end else begin
          range_nxt[s1_sensor_r]      = cm_sat;
          await_fall_nxt[s1_sensor_r] = 1'b0;
          done_nxt                    = 1'b1;
        end
      end
      MODE_CMD: begin
        dir_nxt = s1_cmd_r;
        case (s1_cmd_r)
          CMD_FORWARD:  if (!fwd_blk_r) lines_nxt = LINES_FORWARD;
          CMD_BACKWARD: if (!back_blk_r) lines_nxt = LINES_BACKWARD;
          CMD_LEFT:     lines_nxt = LINES_LEFT;
          CMD_RIGHT:    lines_nxt = LINES_RIGHT;
          default:      lines_nxt = LINES_STOP;
        endcase
      end
      MODE_TICK: begin
        if (is_back && range_r[1] < stop_dist_r) begin
          back_blk_nxt = 1'b1;
          lines_nxt    = LINES_STOP;
          alert_nxt    = ALERT_STOP_BACK;
        end else if (is_fwd && range_r[0] < stop_dist_r) begin
          fwd_blk_nxt = 1'b1;
          lines_nxt   = LINES_STOP;
          alert_nxt   = ALERT_STOP_FWD;
        end else if (is_back && range_r[1] < warn_dist_r) begin
          back_blk_nxt = 1'b0;
          alert_nxt    = ALERT_WARN_BACK;
        end else if (is_fwd && range_r[0] < warn_dist_r) begin
          fwd_blk_nxt = 1'b0;
          alert_nxt   = ALERT_WARN_FWD;
        end else begin
          fwd_blk_nxt  = 1'b0;
          back_blk_nxt = 1'b0;
          alert_nxt    = ALERT_CLEAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_dist_r <= STOP_RST;
      warn_dist_r <= WARN_RST;
      scale_r     <= SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STOP:  stop_dist_r <= pwdata[RANGE_W-1:0];
        REG_WARN:  warn_dist_r <= pwdata[RANGE_W-1:0];
        REG_SCALE: scale_r     <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_mode_r   <= in_mode;
      s1_sensor_r <= in_echo_sensor;
      s1_edge_r   <= in_edge_time;
      s1_cmd_r    <= in_command_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        await_fall_r[i] <= 1'b0;
        rise_stamp_r[i] <= '0;
        range_r[i]      <= '0;
      end
      dir_r      <= '0;
      fwd_blk_r  <= 1'b0;
      back_blk_r <= 1'b0;
      lines_r    <= LINES_STOP;
      alert_r    <= ALERT_CLEAR;
    end else if (adv) begin
      for (int i = 0; i < 2; i++) begin
        await_fall_r[i] <= await_fall_nxt[i];
        rise_stamp_r[i] <= rise_stamp_nxt[i];
        range_r[i]      <= range_nxt[i];
      end
      dir_r      <= dir_nxt;
      fwd_blk_r  <= fwd_blk_nxt;
      back_blk_r <= back_blk_nxt;
      lines_r    <= lines_nxt;
      alert_r    <= alert_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_lines_r <= lines_nxt;
      out_alert_r <= alert_nxt;
      out_front_r <= range_nxt[0];
      out_back_r  <= range_nxt[1];
      out_done_r  <= done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_lines = out_lines_r;
  assign out_alert       = out_alert_r;
  assign out_front_range = out_front_r;
  assign out_back_range  = out_back_r;
  assign out_range_done  = out_done_r;

`ifndef SYNTH
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  a_done_only_on_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_mode_r != MODE_ECHO) |=> !out_range_done)
    else $error("range_done set by a non-echo request");

  a_stop_halts_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_mode_r == MODE_TICK &&
     (alert_nxt == ALERT_STOP_FWD || alert_nxt == ALERT_STOP_BACK))
    |=> (out_motor_lines == LINES_STOP))
    else $error("stop verdict left motor lines active");
`endif

endmodule

// ----- tb/tb_ultrasonic_collision_guard_motor.sv -----
`timescale 1ns / 100ps
// Testbench for ultrasonic_collision_guard_motor: streams echo, command and tick requests
// with random gaps and stalls, and checks each result against an in-bench guard model.
// Depends on ucg_pkg and the RTL top level.
module tb_ultrasonic_collision_guard_motor;
  import ucg_pkg::*;

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    HOLD_CYCLES    = 120;
  localparam int    HOLD_AFTER     = 200;
  localparam int    NUM_SETTINGS   = 6;
  localparam int    PHASE_REQS     = 105;
  localparam int    PROD_W         = EDGE_W + SCALE_W;
  localparam logic  SENSOR_FRONT   = 1'b0;
  localparam logic  SENSOR_BACK    = 1'b1;
  localparam mode_t MODE_UNUSED    = 2'd3;
  localparam cmd_t  CMD_STOP_CHAR  = 8'h53;

  typedef struct packed {
    mode_t             mode;
    logic              sensor;
    logic [EDGE_W-1:0] stamp;
    cmd_t              cmd;
  } guard_req_t;

  typedef struct packed {
    lines_t lines;
    alert_t alert;
    range_t front;
    range_t back;
    logic   done;
  } guard_report_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  mode_t              in_mode;
  logic               in_echo_sensor;
  logic [EDGE_W-1:0]  in_edge_time;
  cmd_t               in_command_byte;
  logic               out_valid;
  logic               out_ready;
  lines_t             out_motor_lines;
  alert_t             out_alert;
  range_t             out_front_range;
  range_t             out_back_range;
  logic               out_range_done;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  ultrasonic_collision_guard_motor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_echo_sensor  (in_echo_sensor),
    .in_edge_time    (in_edge_time),
    .in_command_byte (in_command_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_lines (out_motor_lines),
    .out_alert       (out_alert),
    .out_front_range (out_front_range),
    .out_back_range  (out_back_range),
    .out_range_done  (out_range_done),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // guard model state and register copies
  logic               g_armed [2];
  logic [EDGE_W-1:0]  g_rise [2];
  range_t             g_range [2];
  cmd_t               g_dir;
  logic               g_fwd_blk;
  logic               g_back_blk;
  lines_t             g_lines;
  alert_t             g_alert;
  range_t             g_stop;
  range_t             g_warn;
  logic [SCALE_W-1:0] g_scale;

  guard_req_t    pending_q [$];
  guard_report_t report_q [$];

  int   pushed_count;
  int   results_seen;
  int   mismatch_count;
  int   ranges_done;
  int   stop_alerts;
  int   idle_cycles;
  int   gap_left;
  int   burst_left;
  int   hold_left;
  int   style_left;
  int   style;
  int   rx_phase;
  logic hold_used;
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic guard_advance(input guard_req_t r);
    logic [EDGE_W-1:0] width;
    logic [PROD_W-1:0] prod;
    logic              done;
    logic              fwd;
    logic              back;
    done = 1'b0;
    fwd  = (g_dir == CMD_FORWARD);
    back = (g_dir == CMD_BACKWARD);
    case (r.mode)
      MODE_ECHO: begin
        if (!g_armed[r.sensor]) begin
          g_rise[r.sensor]  = r.stamp;
          g_armed[r.sensor] = 1'b1;
        end else begin
          width = r.stamp - g_rise[r.sensor];
          prod  = PROD_W'(width) * PROD_W'(g_scale);
          prod  = prod >> 16;
          g_range[r.sensor] = (prod > PROD_W'(RANGE_MAX)) ? RANGE_MAX : prod[RANGE_W-1:0];
          g_armed[r.sensor] = 1'b0;
          done = 1'b1;
        end
      end
      MODE_CMD: begin
        g_dir = r.cmd;
        case (r.cmd)
          CMD_FORWARD:  if (!g_fwd_blk) g_lines = LINES_FORWARD;
          CMD_BACKWARD: if (!g_back_blk) g_lines = LINES_BACKWARD;
          CMD_LEFT:     g_lines = LINES_LEFT;
          CMD_RIGHT:    g_lines = LINES_RIGHT;
          default:      g_lines = LINES_STOP;
        endcase
      end
      MODE_TICK: begin
        if (back && g_range[SENSOR_BACK] < g_stop) begin
          g_back_blk = 1'b1;
          g_lines    = LINES_STOP;
          g_alert    = ALERT_STOP_BACK;
        end else if (fwd && g_range[SENSOR_FRONT] < g_stop) begin
          g_fwd_blk = 1'b1;
          g_lines   = LINES_STOP;
          g_alert   = ALERT_STOP_FWD;
        end else if (back && g_range[SENSOR_BACK] < g_warn) begin
          g_back_blk = 1'b0;
          g_alert    = ALERT_WARN_BACK;
        end else if (fwd && g_range[SENSOR_FRONT] < g_warn) begin
          g_fwd_blk = 1'b0;
          g_alert   = ALERT_WARN_FWD;
        end else begin
          g_fwd_blk  = 1'b0;
          g_back_blk = 1'b0;
          g_alert    = ALERT_CLEAR;
        end
      end
      default: ;
    endcase
    report_q.push_back('{lines: g_lines, alert: g_alert, front: g_range[SENSOR_FRONT],
                         back: g_range[SENSOR_BACK], done: done});
  endtask

  // sample at the rising edge: check the result first, then predict the new request
  always @(posedge clk) begin : monitor
    guard_report_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (out_range_done) ranges_done = ranges_done + 1;
        if (out_alert == ALERT_STOP_FWD || out_alert == ALERT_STOP_BACK)
          stop_alerts = stop_alerts + 1;
        if (report_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count = mismatch_count + 1;
        end else begin
          want = report_q.pop_front();
          if (out_motor_lines !== want.lines) begin
            $error("motor_lines: expected %h, got %h", want.lines, out_motor_lines);
            mismatch_count = mismatch_count + 1;
          end
          if (out_alert !== want.alert) begin
            $error("alert: expected %0d, got %0d", want.alert, out_alert);
            mismatch_count = mismatch_count + 1;
          end
          if (out_front_range !== want.front) begin
            $error("front_range: expected %0d, got %0d", want.front, out_front_range);
            mismatch_count = mismatch_count + 1;
          end
          if (out_back_range !== want.back) begin
            $error("back_range: expected %0d, got %0d", want.back, out_back_range);
            mismatch_count = mismatch_count + 1;
          end
          if (out_range_done !== want.done) begin
            $error("range_done: expected %0d, got %0d", want.done, out_range_done);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        guard_advance('{mode: in_mode, sensor: in_echo_sensor, stamp: in_edge_time,
                        cmd: in_command_byte});
    end
  end

  // sender: bursts of random length, random gaps
  always @(negedge clk) begin : driver
    guard_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        in_mode         <= nxt.mode;
        in_echo_sensor  <= nxt.sensor;
        in_edge_time    <= nxt.stamp;
        in_command_byte <= nxt.cmd;
        in_valid        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: changing stall styles, plus one long hold-off
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_used && results_seen >= HOLD_AFTER) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (style_left == 0) begin
        style      <= $urandom_range(0, 2);
        style_left <= $urandom_range(16, 96);
      end else begin
        style_left <= style_left - 1;
      end
      case (style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rx_phase % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic add_req(input mode_t m, input logic s, input logic [EDGE_W-1:0] t,
                         input cmd_t c);
    pending_q.push_back('{mode: m, sensor: s, stamp: t, cmd: c});
    pushed_count = pushed_count + 1;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STOP:  g_stop  = value[RANGE_W-1:0];
      REG_WARN:  g_warn  = value[RANGE_W-1:0];
      REG_SCALE: g_scale = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every request has its result, then let the pipeline settle
  task automatic drain();
    while (results_seen < pushed_count) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed rise/fall pairs, commands and ticks; some lone edges and unused modes
  task automatic add_random_traffic(input int n);
    int                made;
    int                pick;
    logic              s;
    logic [EDGE_W-1:0] rise;
    logic [EDGE_W-1:0] w;
    cmd_t              c;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      s    = 1'($urandom_range(0, 1));
      if (pick < 38) begin
        rise = EDGE_W'($urandom);
        case ($urandom_range(0, 3))
          0:       w = EDGE_W'($urandom_range(0, 300));
          1:       w = EDGE_W'($urandom_range(0, 4000));
          2:       w = EDGE_W'($urandom);
          default: w = EDGE_W'($urandom_range(0, 2));
        endcase
        add_req(MODE_ECHO, s, rise, CMD_W'($urandom));
        add_req(MODE_ECHO, s, rise + w, CMD_W'($urandom));
        made = made + 2;
      end else if (pick < 42) begin
        add_req(MODE_ECHO, s, EDGE_W'($urandom), CMD_W'($urandom));
        made = made + 1;
      end else if (pick < 66) begin
        case ($urandom_range(0, 9))
          0, 1, 2: c = CMD_FORWARD;
          3, 4, 5: c = CMD_BACKWARD;
          6:       c = CMD_LEFT;
          7:       c = CMD_RIGHT;
          8:       c = CMD_STOP_CHAR;
          default: c = CMD_W'($urandom);
        endcase
        add_req(MODE_CMD, s, EDGE_W'($urandom), c);
        made = made + 1;
      end else if (pick < 95) begin
        add_req(MODE_TICK, s, EDGE_W'($urandom), CMD_W'($urandom));
        made = made + 1;
      end else begin
        add_req(MODE_UNUSED, s, EDGE_W'($urandom), CMD_W'($urandom));
        made = made + 1;
      end
    end
  endtask

  initial begin : stimulus
    range_t             stops [NUM_SETTINGS];
    range_t             warns [NUM_SETTINGS];
    logic [SCALE_W-1:0] scales [NUM_SETTINGS];
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_ECHO;
    in_echo_sensor  = SENSOR_FRONT;
    in_edge_time    = '0;
    in_command_byte = '0;
    out_ready       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pushed_count    = 0;
    results_seen    = 0;
    mismatch_count  = 0;
    ranges_done     = 0;
    stop_alerts     = 0;
    idle_cycles     = 0;
    gap_left        = 0;
    burst_left      = 1;
    hold_left       = 0;
    style_left      = 0;
    style           = 0;
    rx_phase        = 0;
    hold_used       = 1'b0;
    in_taken        = 1'b0;
    g_armed[0] = 1'b0;  g_armed[1] = 1'b0;
    g_rise[0]  = '0;    g_rise[1]  = '0;
    g_range[0] = '0;    g_range[1] = '0;
    g_dir      = '0;
    g_fwd_blk  = 1'b0;
    g_back_blk = 1'b0;
    g_lines    = LINES_STOP;
    g_alert    = ALERT_CLEAR;
    g_stop     = STOP_RST;
    g_warn     = WARN_RST;
    g_scale    = SCALE_RST;

    stops[0] = STOP_RST; warns[0] = WARN_RST; scales[0] = SCALE_RST;
    stops[1] = 8'd0;     warns[1] = 8'd0;     scales[1] = 16'd0;
    stops[2] = 8'd255;   warns[2] = 8'd255;   scales[2] = 16'hFFFF;
    stops[3] = 8'd40;    warns[3] = 8'd20;    scales[3] = 16'd2000;
    stops[4] = 8'd1;     warns[4] = 8'd200;   scales[4] = 16'd1;
    stops[5] = RANGE_W'($urandom);
    warns[5] = RANGE_W'($urandom);
    scales[5] = SCALE_W'($urandom);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_STOP, STOP_RST);
    cfg_write(REG_WARN, WARN_RST);
    cfg_write(REG_SCALE, SCALE_RST);

    // directed: thresholds, blocking, stamp wrap, equal stamps, saturation
    add_req(MODE_TICK, SENSOR_FRONT, '0, '0);
    add_req(MODE_CMD, SENSOR_FRONT, '0, CMD_FORWARD);
    add_req(MODE_ECHO, SENSOR_FRONT, 16'd0, '0);
    add_req(MODE_ECHO, SENSOR_FRONT, 16'd0, '0);
    add_req(MODE_TICK, SENSOR_FRONT, '0, '0);
    add_req(MODE_CMD, SENSOR_FRONT, '0, CMD_FORWARD);
    add_req(MODE_ECHO, SENSOR_FRONT, 16'hFFFF, '0);
    add_req(MODE_ECHO, SENSOR_FRONT, 16'd1199, '0);
    add_req(MODE_TICK, SENSOR_FRONT, '0, '0);
    add_req(MODE_CMD, SENSOR_FRONT, '0, CMD_FORWARD);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd100, '0);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd99, '0);
    add_req(MODE_CMD, SENSOR_BACK, '0, CMD_BACKWARD);
    add_req(MODE_TICK, SENSOR_BACK, '0, '0);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd5000, '0);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd5500, '0);
    add_req(MODE_TICK, SENSOR_BACK, '0, '0);
    add_req(MODE_CMD, SENSOR_BACK, '0, CMD_BACKWARD);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd0, '0);
    add_req(MODE_ECHO, SENSOR_BACK, 16'd1500, '0);
    add_req(MODE_TICK, SENSOR_BACK, '0, '0);
    add_req(MODE_CMD, SENSOR_BACK, '0, CMD_LEFT);
    add_req(MODE_CMD, SENSOR_BACK, '0, CMD_RIGHT);
    add_req(MODE_CMD, SENSOR_BACK, '0, CMD_STOP_CHAR);
    add_req(MODE_CMD, SENSOR_BACK, '0, 8'hFF);
    add_req(MODE_UNUSED, SENSOR_BACK, 16'hFFFF, 8'hFF);
    add_req(MODE_CMD, SENSOR_FRONT, '0, 8'h00);
    drain();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      cfg_write(REG_STOP, stops[p]);
      cfg_write(REG_WARN, warns[p]);
      cfg_write(REG_SCALE, scales[p]);
      add_random_traffic(PHASE_REQS);
      drain();
    end

    $display("tb: %0d requests checked over %0d register settings", results_seen,
             NUM_SETTINGS + 1);
    $display("tb: %0d completed ranges, %0d stop alerts reported", ranges_done, stop_alerts);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (report_q.size() != 0) $error("%0d results never arrived", report_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
